// File: design/crc31h_pkg.sv
// ----------------------------------------------------------------------------
// crc31h_pkg
// Shared types, constants and the CRC table function for the 31-bit CRC
// name hash with double-hashing slot and step.
// ----------------------------------------------------------------------------
package crc31h_pkg;

  localparam int unsigned SLOT_BITS_DEF = 16;
  localparam int unsigned CRC_W         = 31;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned OUT_TDATA_W   = 64;
  localparam int unsigned CNT_W         = 5;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 31'h4800_0000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1021;
  localparam logic [SIZE_W-1:0] MIN_SIZE   = 16'd3;
  localparam logic [CH_W-1:0]   CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0]   CH_UPPER_Z = 8'h5a;
  localparam logic [CH_W-1:0]   CH_FOLD    = 8'h20;

  // register indexes on the configuration port
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_FOLD_CASE  = 1'b1;

  // one finished name handed from front to back
  typedef struct packed {
    logic [CRC_W-1:0]  crc;
    logic [SIZE_W-1:0] size;   // already clamped to at least 3
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_OUT
  } back_state_t;

  // XOR of (POLY >> j) over each set bit j of the 7-bit index
  function automatic logic [CRC_W-1:0] crc_entry(input logic [6:0] idx);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < 7; j++) begin
      if (idx[j]) begin
        acc = acc ^ (CRC_POLY >> j);
      end
    end
    return acc;
  endfunction

endpackage

// File: design/crc31h_front.sv
// ----------------------------------------------------------------------------
// crc31h_front
// Configuration registers, case folding and the per-character CRC update.
// Pushes one job per name into the queue on the last beat.
// ----------------------------------------------------------------------------
module crc31h_front #(
  parameter int unsigned SLOT_BITS = crc31h_pkg::SLOT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [crc31h_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [crc31h_pkg::CH_W-1:0]         s_tdata,
  input  logic                                s_tlast,
  input  logic                                q_full,
  output logic                                q_push,
  output crc31h_pkg::job_t                    q_job
);

  localparam int unsigned SZ_W = (SLOT_BITS < crc31h_pkg::SIZE_W) ?
                                 SLOT_BITS : crc31h_pkg::SIZE_W;

  logic [SZ_W-1:0]                 table_size;
  logic                            fold_case;
  logic [crc31h_pkg::CRC_W-1:0]    running_crc;
  logic [crc31h_pkg::CRC_W-1:0]    crc_next;
  logic [crc31h_pkg::CH_W-1:0]     ch_f;
  logic [crc31h_pkg::SIZE_W-1:0]   size_ext;
  logic                            beat;

  assign s_tready = !q_full;
  assign beat     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= crc31h_pkg::SIZE_RESET[SZ_W-1:0];
      fold_case  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        crc31h_pkg::REG_TABLE_SIZE: table_size <= cfg_wdata[SZ_W-1:0];
        crc31h_pkg::REG_FOLD_CASE:  fold_case  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ch_f = s_tdata;
    if (fold_case && s_tdata >= crc31h_pkg::CH_UPPER_A &&
        s_tdata <= crc31h_pkg::CH_UPPER_Z) begin
      ch_f = s_tdata + crc31h_pkg::CH_FOLD;
    end
    crc_next = (running_crc >> 7) ^
               crc31h_pkg::crc_entry(running_crc[6:0] ^ ch_f[6:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (beat) begin
      running_crc <= s_tlast ? '0 : crc_next;
    end
  end

  always_comb begin
    size_ext = crc31h_pkg::SIZE_W'(table_size);
    if (size_ext < crc31h_pkg::MIN_SIZE) begin
      size_ext = crc31h_pkg::MIN_SIZE;
    end
    q_push     = beat && s_tlast;
    q_job.crc  = crc_next;
    q_job.size = size_ext;
  end

endmodule

// File: design/crc31h_fifo.sv
// ----------------------------------------------------------------------------
// crc31h_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module crc31h_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crc31h_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output crc31h_pkg::job_t pop_job
);

  crc31h_pkg::job_t mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign pop_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: design/crc31h_back.sv
// ----------------------------------------------------------------------------
// crc31h_back
// Bit-serial remainder unit: crc mod size and crc mod (size-2) in parallel,
// one dividend bit per cycle, then the result into the output register.
// ----------------------------------------------------------------------------
module crc31h_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_avail,
  input  crc31h_pkg::job_t                       q_job,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [crc31h_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int unsigned W = crc31h_pkg::SIZE_W;

  crc31h_pkg::back_state_t         state, state_next;
  logic [crc31h_pkg::CNT_W-1:0]    cnt;
  logic [crc31h_pkg::CRC_W-1:0]    crc_hold;
  logic [crc31h_pkg::CRC_W-1:0]    crc_sh;
  logic [W-1:0]                    d1, d2, r1, r2;
  logic [W:0]                      t1, t2;
  logic [W-1:0]                    r1_next, r2_next;
  logic                            load;
  logic                            out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    t1 = {r1, crc_sh[crc31h_pkg::CRC_W-1]};
    t2 = {r2, crc_sh[crc31h_pkg::CRC_W-1]};
    r1_next = (t1 >= {1'b0, d1}) ? W'(t1 - {1'b0, d1}) : t1[W-1:0];
    r2_next = (t2 >= {1'b0, d2}) ? W'(t2 - {1'b0, d2}) : t2[W-1:0];
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    unique case (state)
      crc31h_pkg::B_IDLE: begin
        if (q_avail) begin
          q_pop      = 1'b1;
          state_next = crc31h_pkg::B_RUN;
        end
      end
      crc31h_pkg::B_RUN: begin
        if (cnt == '0) begin
          state_next = crc31h_pkg::B_OUT;
        end
      end
      crc31h_pkg::B_OUT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = crc31h_pkg::B_IDLE;
        end
      end
      default: state_next = crc31h_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crc31h_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      crc_hold <= q_job.crc;
      crc_sh   <= q_job.crc;
      d1       <= q_job.size;
      d2       <= q_job.size - W'(2);
      r1       <= '0;
      r2       <= '0;
      cnt      <= crc31h_pkg::CNT_W'(crc31h_pkg::CRC_W - 1);
    end else if (state == crc31h_pkg::B_RUN) begin
      crc_sh <= crc_sh << 1;
      r1     <= r1_next;
      r2     <= r2_next;
      cnt    <= cnt - crc31h_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // tdata: crc_value[30:0], home_slot[46:31], probe_step[62:47], pad[63]
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, d2 - r2, r1, crc_hold};
    end
  end

endmodule

// File: design/crc31_string_double_hash_index.sv
// Throughput: one character per cycle at the input while the queue is not
// full; the back end takes a name from the queue only after the last
// name's result is loaded into the output register, and a two-entry queue
// lets the front keep hashing the next names meanwhile.
// Reset (synchronous, rst high): running CRC, queue and output cleared,
// table_size back to 1021, fold_case off.
// ----------------------------------------------------------------------------
// crc31_string_double_hash_index
// 31-bit CRC name hash giving home slot and double-hashing probe step.
// ----------------------------------------------------------------------------
module crc31_string_double_hash_index #(
  parameter int unsigned SLOT_BITS = crc31h_pkg::SLOT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_index,
  input  logic [crc31h_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [crc31h_pkg::CH_W-1:0]          s_tdata,   // ch[7:0]
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // crc_value[30:0], home_slot[46:31], probe_step[62:47], zero[63]
  output logic [crc31h_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_avail;
  crc31h_pkg::job_t push_job;
  crc31h_pkg::job_t pop_job;

  crc31h_front #(
    .SLOT_BITS (SLOT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  crc31h_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  crc31h_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: design/crc31h_checker.sv
// ----------------------------------------------------------------------------
// crc31h_checker
// Port-level checks on the hash block's result stream.
// ----------------------------------------------------------------------------
module crc31h_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [crc31h_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[63])
    else $error("pad bit set");

  // step is at least 1
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[62:47] != 16'd0)
    else $error("zero probe step");

  // home slot is below the largest table size
  a_home_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:31] != 16'hffff)
    else $error("home slot out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

endmodule

bind crc31_string_double_hash_index crc31h_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
